// File: hw/rtl/pbpu_pkg.sv
// Shared types and constants for the packed bitmap pixel unpacker.
// Used by every module of the block; depends on nothing else.
package pbpu_pkg;

  // Default largest row length and frame height in pixels.
  localparam int unsigned MaxDimensionDef = 4096;

  // Width of the configuration write data that carries line_width and line_count.
  localparam int unsigned CfgW = 13;

  // Width of the configuration register index.
  localparam int unsigned CfgAddrW = 2;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_LINE_WIDTH = 2'd0,
    CFG_LINE_COUNT = 2'd1,
    CFG_PIXEL_MODE = 2'd2
  } pbpu_cfg_e;

  // Pixel packing of one byte.
  typedef enum logic {
    MODE_MONO = 1'b0,
    MODE_QUAD = 1'b1
  } pbpu_mode_e;

  // One classified byte waiting for the back.
  typedef struct packed {
    pbpu_mode_e mode;
    logic [7:0] data;
  } pbpu_entry_t;

  // Write side of the queue.
  typedef struct packed {
    logic        push;
    pbpu_entry_t entry;
  } pbpu_push_t;

  // Read side of the queue as seen by the back.
  typedef struct packed {
    logic        valid;
    pbpu_entry_t entry;
  } pbpu_head_t;

endpackage

// File: hw/rtl/packed_bitmap_pixel_unpacker.sv
// Packed bitmap pixel unpacker, top level.
// Bytes of packed image data enter on the slave stream; one pixel index per
// beat leaves on the master stream. In mono mode a byte gives up to eight
// pixels, most significant bit first; in 16-color mode the high nibble and
// then the low nibble. A row ends on a byte boundary, and leftover bits of
// that byte are dropped. Size and mode are set on the configuration channel
// (index 0 line_width, 1 line_count, 2 pixel_mode). The user must write them
// only while the block is idle; the block itself does not enforce this.
// A byte is held in the queue, and each of its pixels then passes through
// the single pixel-output register of the back part, one pixel per cycle
// while the receiver keeps up; a byte yields 1 to 8 pixels. A two-entry
// queue lets bytes be taken while the back part is busy with earlier ones.
// If the receiver stalls, the output register holds its beat, the back part
// stops, and once the queue fills s_axis_tready drops. Reset empties the
// queue and output, zeroes row and column, and sets width 1, height 1, mono.
// Depends on pbpu_pkg, pbpu_front, pbpu_queue and pbpu_back.
module packed_bitmap_pixel_unpacker #(
  parameter int unsigned MAX_DIMENSION = pbpu_pkg::MaxDimensionDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] packed_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [3:0] pixel_value, [7:4] zero
  output logic [1:0]                    m_axis_tuser,  // [0] byte_done, [1] row_end
  output logic                          m_axis_tlast,  // frame_end
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pbpu_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [pbpu_pkg::CfgW-1:0]     cfg_data_i
);
  import pbpu_pkg::*;

  localparam int unsigned PosW  = $clog2(MAX_DIMENSION);
  localparam int unsigned DimW  = (PosW + 1 > CfgW) ? PosW + 1 : CfgW;

  pbpu_push_t      push;
  pbpu_head_t      head;
  logic            queue_full;
  logic            pop;
  logic [DimW-1:0] width;
  logic [DimW-1:0] height;
  logic [3:0]      pixel_value;

  pbpu_front #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .DIM_W         (DimW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .width_o      (width),
    .height_o     (height)
  );

  pbpu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .pop_i  (pop),
    .head_o (head)
  );

  pbpu_back #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .DIM_W         (DimW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .width_i       (width),
    .height_i      (height),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_value_o (pixel_value),
    .byte_done_o   (m_axis_tuser[0]),
    .row_end_o     (m_axis_tuser[1]),
    .frame_end_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, pixel_value};

endmodule

// File: hw/rtl/pbpu_front.sv
// Front part: configuration registers and acceptance of packed bytes.
// Depends on pbpu_pkg; feeds pbpu_queue and hands the image size to pbpu_back.
module pbpu_front #(
  parameter int unsigned MAX_DIMENSION = pbpu_pkg::MaxDimensionDef,
  parameter int unsigned DIM_W = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input byte channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_data_i,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pbpu_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [pbpu_pkg::CfgW-1:0]     cfg_data_i,
  // Queue write side
  input  logic                          queue_full_i,
  output pbpu_pkg::pbpu_push_t          push_o,
  // Clamped image size
  output logic [DIM_W-1:0]              width_o,
  output logic [DIM_W-1:0]              height_o
);
  import pbpu_pkg::*;

  localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIMENSION);

  logic [DIM_W-1:0] width_q, width_d;
  logic [DIM_W-1:0] height_q, height_d;
  pbpu_mode_e       mode_q, mode_d;
  logic [DIM_W-1:0] cfg_ext;
  logic [DIM_W-1:0] cfg_clamped;

  // A size of zero counts as one; sizes beyond the maximum saturate.
  assign cfg_ext = DIM_W'(cfg_data_i);
  always_comb begin
    priority if (cfg_ext == '0) begin
      cfg_clamped = DIM_W'(1);
    end else if (cfg_ext > MaxDim) begin
      cfg_clamped = MaxDim;
    end else begin
      cfg_clamped = cfg_ext;
    end
  end

  // Register writes; indexes beyond the list are ignored.
  assign cfg_ready_o = 1'b1;
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    mode_d   = mode_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_LINE_WIDTH: width_d  = cfg_clamped;
        CFG_LINE_COUNT: height_d = cfg_clamped;
        CFG_PIXEL_MODE: mode_d   = pbpu_mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      mode_q   <= MODE_MONO;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      mode_q   <= mode_d;
    end
  end

  // Each accepted byte is tagged with its packing and queued.
  assign in_ready_o         = !queue_full_i;
  assign push_o.push        = in_valid_i && !queue_full_i;
  assign push_o.entry.mode  = mode_q;
  assign push_o.entry.data  = in_data_i;

  assign width_o  = width_q;
  assign height_o = height_q;

endmodule

// File: hw/rtl/pbpu_queue.sv
// Short queue of classified bytes between the front and the back.
// Depends on pbpu_pkg for the entry type and the depth.
module pbpu_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pbpu_pkg::pbpu_push_t push_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output pbpu_pkg::pbpu_head_t head_o
);
  import pbpu_pkg::*;

  localparam logic [QueuePtrW-1:0] LastPtr = QueuePtrW'(QueueDepth - 1);
  localparam logic [QueueCntW-1:0] FullCnt = QueueCntW'(QueueDepth);

  pbpu_entry_t          mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == FullCnt);
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + QueuePtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + QueuePtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + QueueCntW'(1);
      2'b01:   count_d = count_q - QueueCntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

endmodule

// File: hw/rtl/pbpu_back.sv
// Back part: walks the head byte one pixel per cycle while the output register
// is free, tracks row and column, and holds the result there. Depends on pbpu_pkg.
module pbpu_back #(
  parameter int unsigned MAX_DIMENSION = pbpu_pkg::MaxDimensionDef,
  parameter int unsigned DIM_W = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pbpu_pkg::pbpu_head_t head_i,
  output logic                 pop_o,
  input  logic [DIM_W-1:0]     width_i,
  input  logic [DIM_W-1:0]     height_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           pixel_value_o,
  output logic                 byte_done_o,
  output logic                 row_end_o,
  output logic                 frame_end_o
);
  import pbpu_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_DIMENSION);

  logic [PosW-1:0]  col_q, col_d;
  logic [PosW-1:0]  row_q, row_d;
  logic [2:0]       idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [3:0]       pix_q;
  logic             done_q, rend_q, fend_q;

  logic             emit;
  logic [3:0]       pix;
  logic             byte_last;
  logic             rend;
  logic             fend;
  logic             done;
  logic [DIM_W-1:0] col_next;
  logic [DIM_W-1:0] row_next;

  // A pixel moves out when a byte waits and the output register is free.
  assign emit = head_i.valid && (!out_valid_q || out_ready_i);

  // Pick the pixel at the current place in the byte.
  always_comb begin
    unique case (head_i.entry.mode)
      MODE_MONO: begin
        pix       = {3'b000, head_i.entry.data[3'd7 - idx_q]};
        byte_last = (idx_q == 3'd7);
      end
      MODE_QUAD: begin
        pix       = idx_q[0] ? head_i.entry.data[3:0] : head_i.entry.data[7:4];
        byte_last = idx_q[0];
      end
      default: begin
        pix       = '0;
        byte_last = 1'b1;
      end
    endcase
  end

  // Row and frame ends; a position already past a new size ends at once.
  assign col_next = DIM_W'(col_q) + DIM_W'(1);
  assign row_next = DIM_W'(row_q) + DIM_W'(1);
  assign rend     = (col_next >= width_i);
  assign fend     = rend && (row_next >= height_i);
  assign done     = byte_last || rend;
  assign pop_o    = emit && done;

  // Position and in-byte index updates.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    idx_d = idx_q;
    if (emit) begin
      idx_d = done ? 3'd0 : idx_q + 3'd1;
      if (rend) begin
        col_d = '0;
        row_d = fend ? '0 : row_next[PosW-1:0];
      end else begin
        col_d = col_next[PosW-1:0];
      end
    end
  end

  // The output register holds until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded on each emitted pixel.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      pix_q  <= pix;
      done_q <= done;
      rend_q <= rend;
      fend_q <= fend;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pix_q;
  assign byte_done_o   = done_q;
  assign row_end_o     = rend_q;
  assign frame_end_o   = fend_q;

endmodule
